// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the active-low reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define ASSERT_ALL(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/i2cs16_pkg.sv =====
package i2cs16_pkg;

  localparam int unsigned PhaseW = 3;

  // Sequencer phases.
  localparam logic [PhaseW-1:0] PhIdle     = 3'd0;
  localparam logic [PhaseW-1:0] PhStart    = 3'd1;
  localparam logic [PhaseW-1:0] PhAddr     = 3'd2;
  localparam logic [PhaseW-1:0] PhRestart  = 3'd3;
  localparam logic [PhaseW-1:0] PhSlaR     = 3'd4;
  localparam logic [PhaseW-1:0] PhRead     = 3'd5;
  localparam logic [PhaseW-1:0] PhStopping = 3'd6;

  // Request kinds.
  localparam logic FuncBegin = 1'b0;
  localparam logic FuncEvent = 1'b1;

  // Bus event codes; all other codes count as arbitration lost.
  localparam logic [2:0] EvStartDone = 3'd0;
  localparam logic [2:0] EvAck       = 3'd1;
  localparam logic [2:0] EvNack      = 3'd2;
  localparam logic [2:0] EvStopDone  = 3'd3;

  // Address byte counter values in the address phase.
  localparam logic [1:0] CntSla     = 2'd0;
  localparam logic [1:0] CntAddrHi  = 2'd1;
  localparam logic [1:0] CntAddrLo  = 2'd2;
  localparam logic [1:0] CntData    = 2'd3;

  localparam logic RdWrite = 1'b0;
  localparam logic RdRead  = 1'b1;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [1:0]        sent_count;
    logic              read_mode;
    logic [6:0]        target_addr;
    logic [15:0]       register_addr;
    logic [7:0]        data_out;
    logic [7:0]        data_in;
    logic              error_seen;
  } seq_state_t;

  typedef struct packed {
    logic        func;
    logic        is_read;
    logic [6:0]  device_addr;
    logic [15:0] reg_addr;
    logic [7:0]  write_byte;
    logic [2:0]  bus_event;
    logic [7:0]  rx_byte;
  } req_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       failed;
    logic       done_res;
    logic       trigger;
    logic       send_stop;
    logic       send_start;
    logic [7:0] tx_byte;
    logic       tx_load;
  } result_t;

endpackage

// ===== rtl/core/i2cs16_step.sv =====
module i2cs16_step
  import i2cs16_pkg::*;
(
  input  seq_state_t state_i,
  input  req_item_t  item_i,
  output seq_state_t state_o,
  output result_t    result_o
);

  logic [7:0] sla_w;

  assign sla_w = {state_i.target_addr, 1'b0};

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (item_i.func == FuncBegin) begin
      // A begin request while a transfer runs is dropped.
      if (state_i.phase == PhIdle) begin
        state_o.read_mode     = item_i.is_read;
        state_o.target_addr   = item_i.device_addr;
        state_o.register_addr = item_i.reg_addr;
        state_o.data_out      = item_i.write_byte;
        state_o.data_in       = '0;
        state_o.error_seen    = 1'b0;
        state_o.sent_count    = CntSla;
        state_o.phase         = PhStart;
        result_o.send_start   = 1'b1;
        result_o.trigger      = 1'b1;
      end
    end else if (state_i.phase != PhIdle) begin
      unique case (item_i.bus_event)
        EvStopDone: begin
          result_o.trigger  = 1'b1;
          result_o.done_res = 1'b1;
          result_o.failed   = state_i.error_seen || (state_i.phase != PhStopping);
          if (!result_o.failed && (state_i.read_mode == RdRead)) begin
            result_o.read_byte = state_i.data_in;
          end
          state_o.phase = PhIdle;
        end
        EvStartDone: begin
          result_o.trigger = 1'b1;
          if (state_i.phase == PhStart) begin
            result_o.tx_load   = 1'b1;
            result_o.tx_byte   = sla_w;
            state_o.sent_count = CntSla;
            state_o.phase      = PhAddr;
          end else if (state_i.phase == PhRestart) begin
            result_o.tx_load = 1'b1;
            result_o.tx_byte = sla_w | 8'h01;
            state_o.phase    = PhSlaR;
          end
        end
        EvAck: begin
          result_o.trigger = 1'b1;
          if (state_i.phase == PhAddr) begin
            unique case (state_i.sent_count)
              CntSla: begin
                result_o.tx_load   = 1'b1;
                result_o.tx_byte   = state_i.register_addr[15:8];
                state_o.sent_count = CntAddrHi;
              end
              CntAddrHi: begin
                result_o.tx_load   = 1'b1;
                result_o.tx_byte   = state_i.register_addr[7:0];
                state_o.sent_count = CntAddrLo;
              end
              CntAddrLo: begin
                if (state_i.read_mode == RdRead) begin
                  result_o.send_start = 1'b1;
                  state_o.phase       = PhRestart;
                end else begin
                  result_o.tx_load   = 1'b1;
                  result_o.tx_byte   = state_i.data_out;
                  state_o.sent_count = CntData;
                end
              end
              default: begin
                result_o.send_stop = 1'b1;
                state_o.phase      = PhStopping;
              end
            endcase
          end else if (state_i.phase == PhSlaR) begin
            state_o.phase = PhRead;
          end
        end
        EvNack: begin
          result_o.send_stop = 1'b1;
          result_o.trigger   = 1'b1;
          state_o.phase      = PhStopping;
          if (state_i.phase == PhRead) begin
            state_o.data_in = item_i.rx_byte;
          end else begin
            state_o.error_seen = 1'b1;
          end
        end
        default: begin
          result_o.send_stop = 1'b1;
          result_o.trigger   = 1'b1;
          state_o.error_seen = 1'b1;
          state_o.phase      = PhStopping;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/i2c_master_reg16_byte_sequencer.sv =====
// Control sequencer for one single-byte I2C read or write to a target with a 16-bit
// register address. Each request (a begin command, or one bus event reported by the
// protocol engine) yields exactly one result, which carries the byte to load, the
// START/STOP requests and the trigger, and on STOP completion the done flag, the error
// flag and the read byte. A request is taken every clock cycle while the output buffer
// has room: the sequencer state is updated in the cycle of acceptance, and its result is
// registered in the output register. A two-entry output buffer keeps accepting while
// one result waits, so the slave side stalls only when both entries are full.
module i2c_master_reg16_byte_sequencer
  import i2cs16_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // Fields from bit 0: is_read, device_addr, reg_addr, write_byte, bus_event, rx_byte.
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // Fields from bit 0: func.
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // Fields from bit 0: tx_load, tx_byte, send_start, send_stop, trigger, done_res,
  // failed, read_byte.
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  seq_state_t state_q, state_d;
  req_item_t  item;
  result_t    result;
  result_t    out_q, skid_q;
  logic       out_valid_q, skid_valid_q;
  logic       in_acc, out_pop;

  assign item.func        = s_axis_tuser_i;
  assign item.is_read     = s_axis_tdata_i[0];
  assign item.device_addr = s_axis_tdata_i[7:1];
  assign item.reg_addr    = s_axis_tdata_i[23:8];
  assign item.write_byte  = s_axis_tdata_i[31:24];
  assign item.bus_event   = s_axis_tdata_i[34:32];
  assign item.rx_byte     = s_axis_tdata_i[42:35];

  i2cs16_step u_step (
    .state_i  (state_q),
    .item_i   (item),
    .state_o  (state_d),
    .result_o (result)
  );

  assign s_axis_tready_o = !skid_valid_q;
  assign in_acc          = s_axis_tvalid_i && !skid_valid_q;
  assign out_pop         = out_valid_q && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_pop) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (in_acc) begin
      skid_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q};

endmodule

// ===== rtl/core/i2cs16_checker.sv =====
`include "assert_macros.svh"

module i2cs16_checker
  import i2cs16_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic [InDataW-1:0]  s_axis_tdata_i,
  input logic                s_axis_tuser_i,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  result_t res;

  assign res = m_axis_tdata_o[$bits(result_t)-1:0];

  `ASSERT_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")
  `ASSERT_ALL(a_ready_only_full, clk_i, !s_axis_tready_o |-> m_axis_tvalid_o, "input stalled with no result waiting")
  `ASSERT_RST(a_tx_byte_zero, clk_i, rst_ni, m_axis_tvalid_o && !res.tx_load |-> res.tx_byte == 8'h00, "byte shown without load")
  `ASSERT_RST(a_done_shape, clk_i, rst_ni, m_axis_tvalid_o && res.done_res |-> res.trigger && !res.tx_load && !res.send_start && !res.send_stop, "done result carries bus requests")
  `ASSERT_RST(a_read_byte, clk_i, rst_ni, m_axis_tvalid_o && (res.failed || !res.done_res) |-> res.read_byte == 8'h00, "read byte shown without a good finish")

endmodule

bind i2c_master_reg16_byte_sequencer i2cs16_checker u_checker (.*);
